// ===== rtl/tsr_pkg.sv =====
package tsr_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int BAND_ROWS  = 64;
    localparam int COORD_BITS = 12;

    localparam int EDGE_W  = 40;
    localparam int ROW_W   = COORD_BITS + 1;
    localparam int DVD_W   = COORD_BITS + FRAC_BITS;
    localparam int CNT_W   = $clog2(DVD_W + 1);
    localparam int XW      = 10;
    localparam int CW      = 8;
    localparam int IN_W    = 6 * COORD_BITS + CW;
    localparam int OUT_W   = 40;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 2;

    localparam logic [CIDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_BAND   = 2'd2;

    localparam logic SIDE_L = 1'b0;
    localparam logic SIDE_R = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_L,
        ST_DIV_R,
        ST_ROWS,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic load;
        logic div_start;
        logic div_side;
        logic store_l;
        logic store_r;
        logic edge_init;
        logic row_step;
        logic flush;
        logic pass;
    } t_cmd;

    typedef struct packed {
        logic pass_ok;
        logic div_done;
        logic row_done;
        logic step_ok;
        logic flush_ok;
    } t_sts;

endpackage

// ===== rtl/tsr_ctrl.sv =====
module tsr_ctrl
    import tsr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_pass, n_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pass     = r_pass;
        o_cmd      = '0;
        o_cmd.pass = r_pass;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = 1'b0;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_sts.pass_ok) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_side  = SIDE_L;
                    n_state         = ST_DIV_L;
                end else if (!r_pass) begin
                    n_pass = 1'b1;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_DIV_L: begin
                if (i_sts.div_done) begin
                    o_cmd.store_l   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_side  = SIDE_R;
                    n_state         = ST_DIV_R;
                end
            end
            ST_DIV_R: begin
                if (i_sts.div_done) begin
                    o_cmd.store_r   = 1'b1;
                    o_cmd.edge_init = 1'b1;
                    n_state         = ST_ROWS;
                end
            end
            ST_ROWS: begin
                if (i_sts.row_done) begin
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = ST_CHECK;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end else if (i_sts.step_ok) begin
                    o_cmd.row_step = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (i_sts.flush_ok) begin
                    o_cmd.flush = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/tsr_datapath.sv =====
module tsr_datapath
    import tsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [IN_W-1:0]   i_s_tdata,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,
    output logic              o_m_tlast
);

    localparam int CB = COORD_BITS;

    // configuration
    logic [CFG_W-1:0] r_width, r_height;
    logic [XW-1:0]    r_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CFG_W'(320);
            r_height <= CFG_W'(200);
            r_band   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_BAND:   r_band   <= i_cfg_data[XW-1:0];
                default: ;
            endcase
        end
    end

    // vertex sort
    logic signed [CB-1:0] vx [3];
    logic signed [CB-1:0] vy [3];
    logic [1:0] up, lo, mid;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            vx[c] = i_s_tdata[2*c*CB +: CB];
            vy[c] = i_s_tdata[(2*c+1)*CB +: CB];
        end
        up = 2'd0;
        lo = 2'd0;
        if (vy[1] < vy[0]) up = 2'd1;
        if (vy[1] > vy[0]) lo = 2'd1;
        if (vy[2] < vy[up]) up = 2'd2;
        if (vy[2] > vy[lo]) lo = 2'd2;
        mid = 2'd0;
        if (lo == 2'd0 || up == 2'd0) mid = 2'd1;
        if ((lo == 2'd1 || up == 2'd1) && mid == 2'd1) mid = 2'd2;
        if ((lo == 2'd2 || up == 2'd2) && mid == 2'd2) mid = 2'd0;
    end

    logic signed [CB-1:0] r_xu, r_yu, r_xm, r_ym, r_xl, r_yl;
    logic [CW-1:0]        r_colour;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_xu <= vx[up];  r_yu <= vy[up];
            r_xm <= vx[mid]; r_ym <= vy[mid];
            r_xl <= vx[lo];  r_yl <= vy[lo];
            r_colour <= i_s_tdata[6*CB +: CW];
        end
    end

    // shared slope divider, restoring, one quotient bit a cycle
    logic signed [CB:0] dx, dy;
    logic [CB-1:0]      dx_mag;

    always_comb begin
        case ({i_cmd.pass, i_cmd.div_side})
            {1'b0, SIDE_L}: begin dx = r_xu - r_xm; dy = r_ym - r_yu; end
            {1'b0, SIDE_R}: begin dx = r_xl - r_xu; dy = r_yl - r_yu; end
            {1'b1, SIDE_L}: begin dx = r_xm - r_xl; dy = r_yl - r_ym; end
            default:        begin dx = r_xu - r_xl; dy = r_yl - r_yu; end
        endcase
        dx_mag = dx[CB] ? CB'(-dx) : dx[CB-1:0];
    end

    logic [CNT_W-1:0] r_div_cnt;
    logic [DVD_W-1:0] r_quo;
    logic [CB:0]      r_rem;
    logic [CB-1:0]    r_dvs;
    logic             r_neg;
    logic [CB:0]      shifted;

    assign shifted = {r_rem[CB-1:0], r_quo[DVD_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_div_cnt <= CNT_W'(DVD_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo <= {dx_mag, {FRAC_BITS{1'b0}}};
            r_rem <= '0;
            r_dvs <= dy[CB-1:0];
            r_neg <= dx[CB];
        end else if (r_div_cnt != '0) begin
            if (shifted >= {1'b0, r_dvs}) begin
                r_rem <= shifted - {1'b0, r_dvs};
                r_quo <= {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted;
                r_quo <= {r_quo[DVD_W-2:0], 1'b0};
            end
        end
    end

    logic signed [EDGE_W-1:0] quo_ext, slope;
    assign quo_ext = EDGE_W'(r_quo);
    assign slope   = r_neg ? -quo_ext : quo_ext;

    // edge walkers
    logic signed [EDGE_W-1:0] r_lx, r_rx, r_ls, r_rs;
    logic signed [ROW_W-1:0]  r_row;
    logic signed [ROW_W-1:0]  ym_ext;
    logic signed [EDGE_W-1:0] x0;

    assign ym_ext = ROW_W'(r_ym);
    assign x0     = EDGE_W'(i_cmd.pass ? r_xl : r_xu) <<< FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_l) r_ls <= slope;
        if (i_cmd.store_r) r_rs <= slope;
        if (i_cmd.edge_init) begin
            r_lx  <= x0;
            r_rx  <= x0;
            r_row <= ROW_W'(i_cmd.pass ? r_yl : r_yu);
        end else if (i_cmd.row_step) begin
            r_lx  <= i_cmd.pass ? r_lx + r_ls : r_lx - r_ls;
            r_rx  <= r_rx + r_rs;
            r_row <= i_cmd.pass ? r_row - 1'b1 : r_row + 1'b1;
        end
    end

    // span candidate for the current row
    logic [CFG_W-1:0] hlim, wcl;
    logic [XW-1:0]    wmax, xa, xb;
    logic             hit;
    logic signed [EDGE_W-FRAC_BITS-1:0] la, lb;

    always_comb begin
        hlim = (r_height > CFG_W'(1024)) ? CFG_W'(1024) : r_height;
        wcl  = (r_width == '0) ? CFG_W'(1)
             : ((r_width > CFG_W'(1024)) ? CFG_W'(1024) : r_width);
        wmax = XW'(wcl - 1'b1);
        la   = r_lx[EDGE_W-1:FRAC_BITS];
        lb   = r_rx[EDGE_W-1:FRAC_BITS];
        if (la < 0)                     xa = '0;
        else if (la > $signed({1'b0, wmax})) xa = wmax;
        else                            xa = la[XW-1:0];
        if (lb < 0)                     xb = '0;
        else if (lb > $signed({1'b0, wmax})) xb = wmax;
        else                            xb = lb[XW-1:0];
        hit = !r_row[ROW_W-1]
            && (r_row < $signed({1'b0, ROW_W'(hlim)}))
            && (r_row >= $signed(ROW_W'(r_band)))
            && (r_row < $signed(ROW_W'(r_band) + ROW_W'(BAND_ROWS)));
    end

    // pending span (last flag unknown yet) and output register
    logic             r_p_vld, r_o_vld, r_o_last;
    logic [XW-1:0]    r_p_row, r_p_start, r_p_len, r_o_row, r_o_start, r_o_len;
    logic [CW-1:0]    r_o_colour;
    logic             o_free, push, take;

    assign o_free = !r_o_vld || i_m_tready;
    assign take   = i_cmd.row_step && hit;
    assign push   = r_p_vld && (take || i_cmd.flush);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (i_cmd.load)       r_p_vld <= 1'b0;
            else if (take)        r_p_vld <= 1'b1;
            else if (i_cmd.flush) r_p_vld <= 1'b0;
            if (push)             r_o_vld <= 1'b1;
            else if (i_m_tready)  r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_p_row   <= r_row[XW-1:0];
            r_p_start <= (xa < xb) ? xa : xb;
            r_p_len   <= (xa > xb) ? xa - xb : xb - xa;
        end
        if (push) begin
            r_o_row    <= r_p_row;
            r_o_start  <= r_p_start;
            r_o_len    <= r_p_len;
            r_o_colour <= r_colour;
            r_o_last   <= i_cmd.flush;
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {2'b00, r_o_colour, r_o_len, r_o_start, r_o_row};

    always_comb begin
        o_sts.pass_ok  = i_cmd.pass ? (r_yl != r_ym && r_yl != r_yu)
                                    : (r_ym != r_yu && r_yl != r_yu);
        o_sts.div_done = (r_div_cnt == '0);
        o_sts.row_done = i_cmd.pass ? (r_row < ym_ext) : !(r_row < ym_ext);
        o_sts.step_ok  = !(hit && r_p_vld) || o_free;
        o_sts.flush_ok = !r_p_vld || o_free;
    end

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> o_free) else $error("span pushed into full output register");
    a_load_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> !r_p_vld) else $error("pending span survived new triangle");
    a_div_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |=> r_div_cnt == CNT_W'(DVD_W))
        else $error("divider not armed");

endmodule

// ===== rtl/triangle_span_rasterizer.sv =====
// Triangle span rasterizer. One input item is a triangle (three signed 12-bit
// vertices) and a palette colour; the block answers with one span per row that
// lies on screen and inside the band [band_top, band_top+64), rows of the
// upper half rising, then rows of the lower half falling, the final span
// marked by tlast. A triangle with no visible row gives no span. The block
// holds one triangle at a time. Each half begins with a test of its edge
// heights and, when it is drawn, two slope divides on a shared restoring
// divider (one quotient bit per cycle); a skipped half costs the test only.
// Then the edges step once for every row they cover, visible or not, and the
// half closes; a visible row waits for as long as a finished span is pending
// and the output register is still occupied. A final flush step marks the
// last span. No new triangle is taken until the last span has been moved
// into the output register.
module triangle_span_rasterizer
    import tsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: 0 screen_width, 1 screen_height, 2 band_top
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    // tdata: ax, ay, bx, by_row, cx, cy (12 each), fill_colour (8)
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,
    // tdata: span_row, span_start, span_length (10 each), span_colour (8), pad
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,
    // tlast: last_span
    output logic              o_m_tlast
);

    t_cmd cmd;
    t_sts sts;

    tsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    tsr_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tdata  (i_s_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import tsr_pkg::*;

    // one triangle as offered on the input stream
    typedef struct {
        logic signed [COORD_BITS-1:0] ax, ay, bx, by_row, cx, cy;
        logic [CW-1:0]                colour;
    } t_tri;

    // one span as it leaves the block
    typedef struct {
        logic [XW-1:0] row, start, len;
        logic [CW-1:0] colour;
        logic          last;
    } t_span;

    localparam int DRAIN      = 9000;      // worst case: 4096 rows over both passes plus setup
    localparam int CYCLE_MAX  = 3000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    // predictor's copy of the registers
    int unsigned scr_w = 320, scr_h = 200, band = 0;

    t_span span_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    src_idle = 0, sink_idle = 0;   // idle chance in percent
    int    hold_req = 0, hold_cnt = 0;   // long receiver hold-off

    triangle_span_rasterizer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // timeout guard
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_MAX) begin
            $display("[triangle_span_rasterizer] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle);
        end
    end

    // span checker: each accepted item against the oldest expectation
    always @(posedge i_clk) begin
        t_span e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (span_q.size() == 0) begin
                $display("%0t: unexpected span row=%0d start=%0d len=%0d col=%0d last=%0b",
                         $time, m_tdata[9:0], m_tdata[19:10], m_tdata[29:20],
                         m_tdata[37:30], m_tlast);
                errors++;
            end else begin
                e = span_q.pop_front();
                if (m_tdata[9:0] !== e.row || m_tdata[19:10] !== e.start ||
                    m_tdata[29:20] !== e.len || m_tdata[37:30] !== e.colour ||
                    m_tlast !== e.last) begin
                    $display("%0t: span mismatch exp row=%0d start=%0d len=%0d col=%0d last=%0b",
                             $time, e.row, e.start, e.len, e.colour, e.last);
                    $display("%0t:               got row=%0d start=%0d len=%0d col=%0d last=%0b",
                             $time, m_tdata[9:0], m_tdata[19:10], m_tdata[29:20],
                             m_tdata[37:30], m_tlast);
                    errors++;
                end
            end
        end
    end

    // expected spans of one triangle, appended to span_q
    task automatic predict_spans(input t_tri t);
        longint vx[3], vy[3];
        longint lx, rx, ls, rs, row, yend, wmax, hlim, bt, a, b;
        int     up, lo, mid;
        t_span  tmp[$];
        t_span  s;
        vx[0] = longint'(t.ax); vy[0] = longint'(t.ay);
        vx[1] = longint'(t.bx); vy[1] = longint'(t.by_row);
        vx[2] = longint'(t.cx); vy[2] = longint'(t.cy);
        up = 0; lo = 0; mid = 0;
        for (int c = 1; c < 3; c++) begin
            if (vy[c] < vy[up]) up = c;
            if (vy[c] > vy[lo]) lo = c;
        end
        if (lo == 0 || up == 0) mid = 1;
        if ((lo == 1 || up == 1) && mid == 1) mid = 2;
        if ((lo == 2 || up == 2) && mid == 2) mid = 0;
        hlim = longint'((scr_h > 1024) ? 1024 : scr_h);
        wmax = longint'((scr_w == 0) ? 1 : ((scr_w > 1024) ? 1024 : scr_w)) - 64'sd1;
        bt   = longint'(band);
        for (int pass = 0; pass < 2; pass++) begin
            if (pass == 0 && vy[mid] != vy[up] && vy[lo] != vy[up]) begin
                yend = (vy[lo] < vy[mid]) ? vy[lo] : vy[mid];
                ls = ((vx[up] - vx[mid]) <<< FRAC_BITS) / (vy[mid] - vy[up]);
                rs = ((vx[lo] - vx[up]) <<< FRAC_BITS) / (vy[lo] - vy[up]);
                lx = vx[up] <<< FRAC_BITS;
                rx = lx;
                ls = -ls;               // upper half: left edge steps by minus its slope
            end else if (pass == 1 && vy[lo] != vy[mid] && vy[lo] != vy[up]) begin
                yend = (vy[mid] > vy[up]) ? vy[mid] : vy[up];
                ls = ((vx[mid] - vx[lo]) <<< FRAC_BITS) / (vy[lo] - vy[mid]);
                rs = ((vx[up] - vx[lo]) <<< FRAC_BITS) / (vy[lo] - vy[up]);
                lx = vx[lo] <<< FRAC_BITS;
                rx = lx;
            end else begin
                continue;
            end
            row = (pass == 0) ? vy[up] : vy[lo];
            while ((pass == 0) ? (row < yend) : (row >= yend)) begin
                if (row >= 0 && row < hlim && row >= bt && row < bt + BAND_ROWS &&
                    tmp.size() < BAND_ROWS) begin
                    a = lx >>> FRAC_BITS;
                    b = rx >>> FRAC_BITS;
                    a = (a > wmax) ? wmax : ((a < 0) ? 64'sd0 : a);
                    b = (b > wmax) ? wmax : ((b < 0) ? 64'sd0 : b);
                    s.row    = row[XW-1:0];
                    s.start  = (a < b) ? a[XW-1:0] : b[XW-1:0];
                    s.len    = (a > b) ? XW'(a - b) : XW'(b - a);
                    s.colour = t.colour;
                    s.last   = 1'b0;
                    tmp.push_back(s);
                end
                lx += ls;
                rx += rs;
                row += (pass == 0) ? 64'sd1 : -64'sd1;
            end
        end
        if (tmp.size() > 0) tmp[tmp.size()-1].last = 1'b1;
        foreach (tmp[i]) span_q.push_back(tmp[i]);
    endtask

    // offer one triangle, return at the edge it is taken
    task automatic send_tri(input t_tri t);
        if ($urandom_range(99) < src_idle) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t.colour, t.cy, t.cx, t.by_row, t.bx, t.ay, t.ax};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_spans(t);
    endtask

    function automatic t_tri mk(int ax, int ay, int bx, int by, int cx, int cy, int col);
        t_tri t;
        t.ax = COORD_BITS'(ax); t.ay = COORD_BITS'(ay);
        t.bx = COORD_BITS'(bx); t.by_row = COORD_BITS'(by);
        t.cx = COORD_BITS'(cx); t.cy = COORD_BITS'(cy);
        t.colour = CW'(col);
        return t;
    endfunction

    // wait until every span is back and the block has gone quiet
    task automatic drain();
        s_tvalid <= 1'b0;
        while (span_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_regs(input int w, input int h, input int bt);
        drain();
        cfg_we <= 1'b1; cfg_idx <= CFG_WIDTH;  cfg_data <= CFG_W'(w);  @(posedge i_clk);
        cfg_idx <= CFG_HEIGHT; cfg_data <= CFG_W'(h);  @(posedge i_clk);
        cfg_idx <= CFG_BAND;   cfg_data <= CFG_W'(bt); @(posedge i_clk);
        cfg_we <= 1'b0;
        scr_w = w; scr_h = h; band = bt;
    endtask

    // extremes, ties, flat halves, degenerate and clamping cases
    task automatic test_directed();
        send_tri(mk(10, 5, 60, 40, 30, 70, 8'hff));        // plain triangle
        send_tri(mk(10, 5, 60, 5, 30, 50, 8'h00));         // flat top
        send_tri(mk(30, 5, 10, 50, 60, 50, 8'h5a));        // flat bottom
        send_tri(mk(10, 20, 50, 20, 90, 20, 8'h11));       // all rows equal: nothing
        send_tri(mk(40, 3, 40, 30, 40, 60, 8'h22));        // vertical line, zero length
        send_tri(mk(-500, 0, 900, 30, 100, 63, 8'h33));    // clamped both sides
        send_tri(mk(0, -40, 50, -10, 20, -5, 8'h44));      // entirely above screen
        send_tri(mk(2047, 2047, 2047, 2047, 2047, 2047, 8'h55));
        send_tri(mk(-2048, -2048, 2047, 2047, -2048, 2047, 8'haa));
        send_tri(mk(2047, -2048, -2048, 0, 2047, 2047, 8'h0f));
        send_tri(mk(5, 10, 100, 10, 50, 10, 8'hf0));       // degenerate on a visible row
        send_tri(mk(100, 60, 0, 0, 200, 0, 8'h81));        // tie on the upper vertex
        send_tri(mk(0, 0, 200, 60, 100, 60, 8'h7e));       // tie on the lower vertex
        send_tri(mk(319, 10, 330, 20, 310, 30, 8'h01));    // right screen edge
        send_tri(mk(-1, 0, 0, 63, 1, 64, 8'h80));          // band border
    endtask

    function automatic t_tri rnd_tri();
        t_tri t;
        int   y0;
        if ($urandom_range(9) == 0) begin
            {t.ax, t.ay, t.bx, t.by_row, t.cx, t.cy} =
                (6*COORD_BITS)'({$urandom, $urandom, $urandom});
        end else begin
            y0 = int'(band) - 20;
            t.ax = COORD_BITS'(int'($urandom_range(500)) - 60);
            t.bx = COORD_BITS'(int'($urandom_range(500)) - 60);
            t.cx = COORD_BITS'(int'($urandom_range(500)) - 60);
            t.ay = COORD_BITS'(y0 + int'($urandom_range(100)));
            t.by_row = COORD_BITS'(y0 + int'($urandom_range(100)));
            t.cy = COORD_BITS'(y0 + int'($urandom_range(100)));
        end
        t.colour = CW'($urandom);
        return t;
    endfunction

    task automatic test_random(input int n);
        repeat (n) send_tri(rnd_tri());
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        hold_req = 600;
        repeat (6) send_tri(mk(int'($urandom_range(50)), int'(band), 300, int'(band) + 30,
                               int'($urandom_range(200)), int'(band) + 60, int'($urandom)));
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();

        src_idle = 10; sink_idle = 66;
        test_random(20);
        set_regs(1024, 1024, 0);
        test_random(15);
        set_regs(2047, 2047, 1023);
        test_directed();

        src_idle = 66; sink_idle = 10;
        set_regs(0, 0, 0);
        test_random(10);
        set_regs(1, 1, 0);
        test_random(15);
        set_regs(640, 480, 100);
        test_random(20);

        src_idle = 0; sink_idle = 0;
        test_backpressure();
        set_regs(1024, 1024, 960);
        test_random(20);
        set_regs(320, 200, 0);
        test_random(15);

        drain();
        if (errors == 0 && span_q.size() == 0) begin
            $display("[triangle_span_rasterizer] OK");
        end else begin
            $display("[triangle_span_rasterizer] ERROR");
        end
        $finish;
    end

endmodule
